// File: sv/ddiot_pkg.sv
// Shared types and constants for the disk drive I/O and timer unit.
`timescale 1ns / 1ps

package ddiot_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_e;

  localparam int SIDES_DEFAULT = 2;
  localparam int SIDE_BYTES    = 65536;

  localparam logic CFG_DISK_PRESENT = 1'b0;
  localparam logic CFG_DISK_SIDE    = 1'b1;

  localparam logic [11:0] OFF_TIMER_LO = 12'h020;
  localparam logic [11:0] OFF_TIMER_HI = 12'h021;
  localparam logic [11:0] OFF_TIMER_MD = 12'h022;
  localparam logic [11:0] OFF_IO_EN    = 12'h023;
  localparam logic [11:0] OFF_WR_DATA  = 12'h024;
  localparam logic [11:0] OFF_CONTROL  = 12'h025;
  localparam logic [11:0] OFF_STATUS   = 12'h030;
  localparam logic [11:0] OFF_RD_DATA  = 12'h031;
  localparam logic [11:0] OFF_DRIVE    = 12'h032;
  localparam logic [11:0] OFF_EXT      = 12'h033;

  localparam logic [15:0] HEAD_LAST   = 16'd64999;
  localparam logic [7:0]  DELAY_SHORT = 8'd80;
  localparam logic [7:0]  DELAY_LONG  = 8'd255;
  localparam logic [7:0]  STATUS_BASE = 8'h40;
  localparam logic [7:0]  EXT_VALUE   = 8'h80;

  // One item's result, with the data byte still pending on the image memory.
  typedef struct packed {
    logic [7:0] rd;
    logic       handled;
    logic       use_mem;
    logic       in_range;
    logic       irq;
    logic       mirror;
  } res_t;

endpackage

// File: sv/ddiot_image_mem.sv
// Single-port disk image memory with registered read data.
`timescale 1ns / 1ps

module ddiot_image_mem #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/ddiot_regs.sv
// Register file, timer and head logic; issues image memory accesses.
`timescale 1ns / 1ps

module ddiot_regs #(
  parameter int SIDES = ddiot_pkg::SIDES_DEFAULT,
  parameter int AW    = 17
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic                cfg_data_i,
  input  logic                accept_i,
  input  ddiot_pkg::cmd_e     command_i,
  input  logic [11:0]         reg_offset_i,
  input  logic [7:0]          write_data_i,
  input  logic [16:0]         image_address_i,
  input  logic [7:0]          last_byte_i,
  output logic                mem_we_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_addr_o,
  output ddiot_pkg::res_t     res_o
);

  import ddiot_pkg::*;

  localparam int IMAGE_BYTES = SIDES * SIDE_BYTES;

  logic        present_q, side_q;
  logic [15:0] timer_count_q, timer_count_d;
  logic [15:0] timer_reload_q, timer_reload_d;
  logic [1:0]  timer_mode_q, timer_mode_d;
  logic [7:0]  io_enable_q, io_enable_d;
  logic [7:0]  io_control_q, io_control_d;
  logic [1:0]  irq_flags_q, irq_flags_d;
  logic [15:0] head_q, head_d;
  logic [1:0]  skip_q, skip_d;
  logic [7:0]  delay_q, delay_d;
  logic        mirror_q, mirror_d;

  logic [15:0] count_dec;
  logic [7:0]  delay_dec;
  logic [16:0] rd_ix, wr_ix, sel_ix;
  logic        rd_in_range, wr_in_range, ld_in_range;
  logic [31:0] addr_wide;
  logic        we, re;
  res_t        res;

  assign rd_ix       = {side_q, head_q};
  assign wr_ix       = {side_q, head_q - 16'd2};
  assign rd_in_range = 32'(rd_ix) < 32'(IMAGE_BYTES);
  assign wr_in_range = 32'(wr_ix) < 32'(IMAGE_BYTES);
  assign ld_in_range = 32'(image_address_i) < 32'(IMAGE_BYTES);
  assign count_dec   = timer_count_q - 16'd1;
  assign delay_dec   = delay_q - 8'd1;

  always_comb begin
    timer_count_d  = timer_count_q;
    timer_reload_d = timer_reload_q;
    timer_mode_d   = timer_mode_q;
    io_enable_d    = io_enable_q;
    io_control_d   = io_control_q;
    irq_flags_d    = irq_flags_q;
    head_d         = head_q;
    skip_d         = skip_q;
    delay_d        = delay_q;
    mirror_d       = mirror_q;
    we             = 1'b0;
    re             = 1'b0;
    sel_ix         = rd_ix;
    res            = '0;

    case (command_i)
      CMD_TICK: begin
        if (timer_mode_q[1] && timer_count_q != 16'd0) begin
          timer_count_d = count_dec;
          if (count_dec == 16'd0) begin
            if (timer_mode_q[0]) begin
              timer_count_d = timer_reload_q;
            end else begin
              timer_mode_d[1] = 1'b0;
            end
            irq_flags_d[0] = 1'b1;
          end
        end
        if (delay_q != 8'd0) begin
          delay_d = delay_dec;
          if (delay_dec == 8'd0 && io_control_q[7]) begin
            irq_flags_d[1] = 1'b1;
          end
        end
      end
      CMD_READ: begin
        res.handled = reg_offset_i inside {[OFF_STATUS:OFF_EXT]};
        case (reg_offset_i)
          OFF_STATUS: begin
            res.rd      = {6'd0, irq_flags_q};
            irq_flags_d = 2'd0;
          end
          OFF_RD_DATA: begin
            if (!present_q) begin
              res.rd = last_byte_i;
            end else begin
              // data byte arrives from the image memory next cycle
              re           = rd_in_range;
              res.use_mem  = 1'b1;
              res.in_range = rd_in_range;
              if (head_q < HEAD_LAST) begin
                head_d = head_q + 16'd1;
              end
              delay_d        = DELAY_SHORT;
              irq_flags_d[1] = 1'b0;
            end
          end
          OFF_DRIVE: begin
            res.rd = STATUS_BASE;
            if (!present_q) begin
              res.rd = res.rd | 8'h05;
            end
            if (!present_q || !io_control_q[0] || io_control_q[1]) begin
              res.rd = res.rd | 8'h02;
            end
          end
          OFF_EXT: res.rd = EXT_VALUE;
          default: res.rd = 8'd0;
        endcase
      end
      CMD_WRITE: begin
        case (reg_offset_i)
          OFF_TIMER_LO: begin
            timer_reload_d[7:0] = write_data_i;
            irq_flags_d[0]      = 1'b0;
          end
          OFF_TIMER_HI: begin
            timer_reload_d[15:8] = write_data_i;
            irq_flags_d[0]       = 1'b0;
          end
          OFF_TIMER_MD: begin
            timer_mode_d   = write_data_i[1:0];
            timer_count_d  = timer_reload_q;
            irq_flags_d[0] = 1'b0;
          end
          OFF_IO_EN: io_enable_d = write_data_i;
          OFF_WR_DATA: begin
            // head never passes the last track byte, so the limit check always holds
            if (present_q && !io_control_q[2] && io_enable_q[0]) begin
              if (skip_q != 2'd0) begin
                skip_d = skip_q - 2'd1;
              end else if (head_q >= 16'd2) begin
                we     = wr_in_range;
                sel_ix = wr_ix;
              end
            end
          end
          OFF_CONTROL: begin
            irq_flags_d[1] = 1'b0;
            mirror_d       = write_data_i[3];
            if (present_q) begin
              if (!write_data_i[6] && io_control_q[6] && !write_data_i[4]) begin
                head_d  = (head_q >= 16'd2) ? head_q - 16'd2 : 16'd0;
                delay_d = DELAY_LONG;
              end
              if (!write_data_i[2]) begin
                skip_d = 2'd2;
              end
              if (write_data_i[1]) begin
                head_d  = 16'd0;
                delay_d = DELAY_LONG;
              end
              if (write_data_i[6]) begin
                delay_d = DELAY_LONG;
              end
              io_control_d = write_data_i;
            end
          end
          default: ;
        endcase
      end
      CMD_LOAD: begin
        we     = ld_in_range;
        sel_ix = image_address_i;
      end
      default: ;
    endcase

    res.irq    = |irq_flags_d;
    res.mirror = mirror_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q      <= 1'b0;
      side_q         <= 1'b0;
      timer_count_q  <= '0;
      timer_reload_q <= '0;
      timer_mode_q   <= '0;
      io_enable_q    <= '0;
      io_control_q   <= '0;
      irq_flags_q    <= '0;
      head_q         <= '0;
      skip_q         <= '0;
      delay_q        <= '0;
      mirror_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DISK_PRESENT: present_q <= cfg_data_i;
          CFG_DISK_SIDE:    side_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        timer_count_q  <= timer_count_d;
        timer_reload_q <= timer_reload_d;
        timer_mode_q   <= timer_mode_d;
        io_enable_q    <= io_enable_d;
        io_control_q   <= io_control_d;
        irq_flags_q    <= irq_flags_d;
        head_q         <= head_d;
        skip_q         <= skip_d;
        delay_q        <= delay_d;
        mirror_q       <= mirror_d;
      end
    end
  end

  assign addr_wide  = 32'(sel_ix);
  assign mem_addr_o = addr_wide[AW-1:0];
  assign mem_we_o   = accept_i && we;
  assign mem_re_o   = accept_i && re;
  assign res_o      = res;

endmodule

// File: sv/disk_drive_io_timer_unit.sv
// Top level: disk drive I/O unit with interval timer, two-stage result pipeline.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_ready_o    | command, reg_offset, write_data, image_address
//   out     | output    | out_valid_o / out_ready_i  | read_data, read_handled, irq_active, mirror
//   cfg     | input     | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// One item per clock while the output is not stalled; an accepted item passes through the
// register update and image memory read, then the output register.
// The image memory port is read or written at most once per item.
// Reset clears state and valid flags but not result data; image bytes are undefined until loaded.
// With the output stalled, one item waits in each stage, then in_ready_o drops.
`timescale 1ns / 1ps

module disk_drive_io_timer_unit #(
  parameter int SIDES = ddiot_pkg::SIDES_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ddiot_pkg::cmd_e      command_i,
  input  logic [11:0]          reg_offset_i,
  input  logic [7:0]           write_data_i,
  input  logic [16:0]          image_address_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           read_data_o,
  output logic                 read_handled_o,
  output logic                 irq_active_o,
  output logic                 mirror_horizontal_o
);

  import ddiot_pkg::*;

  localparam int DEPTH = SIDES * SIDE_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic          accept;
  logic          s1_valid_q, s1_adv;
  res_t          res, s1_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata, s1_byte, last_byte_q, last_eff;
  logic          out_valid_q;
  logic [7:0]    out_data_q;
  logic          out_handled_q, out_irq_q, out_mirror_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // out-of-image reads return zero
  assign s1_byte  = s1_q.in_range ? mem_rdata : 8'd0;
  assign last_eff = (s1_valid_q && s1_q.use_mem) ? s1_byte : last_byte_q;

  ddiot_regs #(
    .SIDES (SIDES),
    .AW    (AW)
  ) u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (accept),
    .command_i       (command_i),
    .reg_offset_i    (reg_offset_i),
    .write_data_i    (write_data_i),
    .image_address_i (image_address_i),
    .last_byte_i     (last_eff),
    .mem_we_o        (mem_we),
    .mem_re_o        (mem_re),
    .mem_addr_o      (mem_addr),
    .res_o           (res)
  );

  ddiot_image_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (write_data_i),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_byte_q <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv && s1_q.use_mem) begin
        last_byte_q <= s1_byte;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res;
    end
    if (s1_adv) begin
      out_data_q    <= s1_q.use_mem ? s1_byte : s1_q.rd;
      out_handled_q <= s1_q.handled;
      out_irq_q     <= s1_q.irq;
      out_mirror_q  <= s1_q.mirror;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = out_data_q;
  assign read_handled_o      = out_handled_q;
  assign irq_active_o        = out_irq_q;
  assign mirror_horizontal_o = out_mirror_q;

endmodule

// File: tb/drive_unit_checker.sv
// Checker for the disk drive I/O unit: predicts each item's result and compares.
`timescale 1ns / 1ps

module drive_unit_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic            cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  ddiot_pkg::cmd_e command_i,
  input  logic [11:0]     reg_offset_i,
  input  logic [7:0]      write_data_i,
  input  logic [16:0]     image_address_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic [7:0]      read_data_i,
  input  logic            read_handled_i,
  input  logic            irq_active_i,
  input  logic            mirror_horizontal_i,
  output int              fail_count_o,
  output int              pending_o
);

  import ddiot_pkg::*;

  localparam int IMAGE_BYTES = SIDES_DEFAULT * SIDE_BYTES;

  // drive status bits
  localparam logic [7:0] DRV_NO_DISK   = 8'h05;
  localparam logic [7:0] DRV_NOT_READY = 8'h02;

  // control register bit positions
  localparam int CTL_MOTOR   = 0;
  localparam int CTL_REWIND  = 1;
  localparam int CTL_NO_SKIP = 2;
  localparam int CTL_MIRROR  = 3;
  localparam int CTL_HOLD    = 4;
  localparam int CTL_XFER    = 6;
  localparam int CTL_IRQ_EN  = 7;

  localparam int TMR_REPEAT  = 0;
  localparam int TMR_ENABLE  = 1;
  localparam int TMR_FLAG    = 0;
  localparam int DSK_FLAG    = 1;
  localparam int IO_EN_WRITE = 0;

  typedef struct packed {
    logic [7:0] data;
    logic       handled;
    logic       irq;
    logic       mirror;
  } reply_t;

  reply_t replies_due[$];
  int     fails;

  logic        disk_in, side_sel;
  logic [15:0] tmr_count, tmr_latch;
  logic [1:0]  tmr_mode;
  logic [7:0]  io_en, io_ctrl;
  logic [1:0]  irq_bits;
  logic [15:0] head;
  logic [1:0]  skip_left;
  logic [7:0]  xfer_delay;
  logic        mirror;
  logic [7:0]  last_byte;
  logic [7:0]  image_mem [0:IMAGE_BYTES-1];

  task automatic run_drive_command(input cmd_e cmd, input logic [11:0] off,
                                   input logic [7:0] d, input logic [16:0] addr,
                                   output reply_t r);
    r = '0;
    case (cmd)
      CMD_TICK: begin
        if (tmr_mode[TMR_ENABLE] && tmr_count != 16'd0) begin
          tmr_count = tmr_count - 16'd1;
          if (tmr_count == 16'd0) begin
            if (tmr_mode[TMR_REPEAT]) tmr_count = tmr_latch;
            else tmr_mode[TMR_ENABLE] = 1'b0;
            irq_bits[TMR_FLAG] = 1'b1;
          end
        end
        if (xfer_delay != 8'd0) begin
          xfer_delay = xfer_delay - 8'd1;
          if (xfer_delay == 8'd0 && io_ctrl[CTL_IRQ_EN]) irq_bits[DSK_FLAG] = 1'b1;
        end
      end
      CMD_READ: begin
        r.handled = 1'b1;
        case (off)
          OFF_STATUS: begin
            r.data   = {6'd0, irq_bits};
            irq_bits = 2'b00;
          end
          OFF_RD_DATA: begin
            if (disk_in) begin
              last_byte = image_mem[{side_sel, head}];
              if (head < HEAD_LAST) head = head + 16'd1;
              xfer_delay = DELAY_SHORT;
              irq_bits[DSK_FLAG] = 1'b0;
            end
            r.data = last_byte;
          end
          OFF_DRIVE: begin
            r.data = STATUS_BASE;
            if (!disk_in) r.data |= DRV_NO_DISK;
            if (!disk_in || !io_ctrl[CTL_MOTOR] || io_ctrl[CTL_REWIND]) r.data |= DRV_NOT_READY;
          end
          OFF_EXT: r.data = EXT_VALUE;
          default: r.handled = 1'b0;
        endcase
      end
      CMD_WRITE: begin
        case (off)
          OFF_TIMER_LO: begin
            tmr_latch[7:0] = d;
            irq_bits[TMR_FLAG] = 1'b0;
          end
          OFF_TIMER_HI: begin
            tmr_latch[15:8] = d;
            irq_bits[TMR_FLAG] = 1'b0;
          end
          OFF_TIMER_MD: begin
            tmr_mode  = d[1:0];
            tmr_count = tmr_latch;
            irq_bits[TMR_FLAG] = 1'b0;
          end
          OFF_IO_EN: io_en = d;
          OFF_WR_DATA: begin
            // after a control write that clears no-skip, the first two data writes are dropped
            if (disk_in && !io_ctrl[CTL_NO_SKIP] && io_en[IO_EN_WRITE] && head <= HEAD_LAST) begin
              if (skip_left != 2'd0) skip_left = skip_left - 2'd1;
              else if (head >= 16'd2) image_mem[{side_sel, head} - 17'd2] = d;
            end
          end
          OFF_CONTROL: begin
            irq_bits[DSK_FLAG] = 1'b0;
            mirror = d[CTL_MIRROR];
            if (disk_in) begin
              // leaving transfer mode without hold steps the head back two bytes
              if (!d[CTL_XFER] && io_ctrl[CTL_XFER] && !d[CTL_HOLD]) begin
                head       = (head >= 16'd2) ? head - 16'd2 : 16'd0;
                xfer_delay = DELAY_LONG;
              end
              if (!d[CTL_NO_SKIP]) skip_left = 2'd2;
              if (d[CTL_REWIND]) begin
                head       = 16'd0;
                xfer_delay = DELAY_LONG;
              end
              if (d[CTL_XFER]) xfer_delay = DELAY_LONG;
              io_ctrl = d;
            end
          end
          default: ;
        endcase
      end
      CMD_LOAD: image_mem[addr] = d;
      default: ;
    endcase
    r.irq    = |irq_bits;
    r.mirror = mirror;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want, got;
    if (!rst_ni) begin
      disk_in    = 1'b0;
      side_sel   = 1'b0;
      tmr_count  = '0;
      tmr_latch  = '0;
      tmr_mode   = '0;
      io_en      = '0;
      io_ctrl    = '0;
      irq_bits   = '0;
      head       = '0;
      skip_left  = '0;
      xfer_delay = '0;
      mirror     = 1'b0;
      last_byte  = '0;
      fails      = 0;
      replies_due.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_DISK_PRESENT) disk_in = cfg_data_i;
        else side_sel = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        got = '{read_data_i, read_handled_i, irq_active_i, mirror_horizontal_i};
        if (replies_due.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %h", $time, got);
          fails++;
        end else begin
          want = replies_due.pop_front();
          check_field("read_data", want.data, got.data);
          check_field("read_handled", want.handled, got.handled);
          check_field("irq_active", want.irq, got.irq);
          check_field("mirror_horizontal", want.mirror, got.mirror);
        end
      end
      if (in_valid_i && in_ready_i) begin
        run_drive_command(command_i, reg_offset_i, write_data_i, image_address_i, want);
        replies_due.push_back(want);
      end
      pending_o    <= replies_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: tb/disk_drive_io_timer_unit_tb.sv
// Testbench top for the disk drive I/O unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module disk_drive_io_timer_unit_tb;
  import ddiot_pkg::*;

  localparam int RANDOM_ITEMS   = 880;
  localparam int WINDOW         = 96;
  localparam int REWIND_MARGIN  = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 6;

  localparam logic [7:0] CTRL_REWIND  = 8'h02;
  localparam logic [7:0] CTRL_NO_SKIP = 8'h04;
  localparam logic [7:0] CTRL_XFER    = 8'h40;
  localparam logic [7:0] CTRL_IRQ_EN  = 8'h80;
  localparam logic [7:0] TIMER_LOOP   = 8'h03;
  localparam logic [7:0] IO_EN_WRITE  = 8'h01;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_index_i     = 1'b0;
  logic        cfg_data_i      = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  cmd_e        command_i       = CMD_TICK;
  logic [11:0] reg_offset_i    = '0;
  logic [7:0]  write_data_i    = '0;
  logic [16:0] image_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [7:0]  read_data_o;
  logic        read_handled_o;
  logic        irq_active_o;
  logic        mirror_horizontal_o;

  int fail_count;
  int pending;
  int items_sent      = 0;
  int rd_since_rewind = 0;
  bit disk_in_tb      = 1'b0;
  bit steady          = 1'b0;
  bit hold_req        = 1'b0;

  disk_drive_io_timer_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .reg_offset_i       (reg_offset_i),
    .write_data_i       (write_data_i),
    .image_address_i    (image_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .read_data_o        (read_data_o),
    .read_handled_o     (read_handled_o),
    .irq_active_o       (irq_active_o),
    .mirror_horizontal_o(mirror_horizontal_o)
  );

  drive_unit_checker u_chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .command_i          (command_i),
    .reg_offset_i       (reg_offset_i),
    .write_data_i       (write_data_i),
    .image_address_i    (image_address_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .read_data_i        (read_data_o),
    .read_handled_i     (read_handled_o),
    .irq_active_i       (irq_active_o),
    .mirror_horizontal_i(mirror_horizontal_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(input cmd_e cmd, input logic [11:0] off, input logic [7:0] d,
                           input logic [16:0] addr);
    if (!steady && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    reg_offset_i    <= off;
    write_data_i    <= d;
    image_address_i <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    // bound the head so that data reads stay inside the loaded window
    if (cmd == CMD_READ && off == OFF_RD_DATA) rd_since_rewind++;
    if (cmd == CMD_WRITE && off == OFF_CONTROL && d[1] && disk_in_tb) rd_since_rewind = 0;
  endtask

  task automatic do_read(input logic [11:0] off);
    send_item(CMD_READ, off, 8'($urandom), 17'($urandom));
  endtask

  task automatic do_write(input logic [11:0] off, input logic [7:0] d);
    send_item(CMD_WRITE, off, d, 17'($urandom));
  endtask

  task automatic do_ticks(input int n);
    repeat (n) send_item(CMD_TICK, 12'($urandom), 8'($urandom), 17'($urandom));
  endtask

  // drop valid and hold until every outstanding result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_drive(input logic present, input logic side);
    drain();
    disk_in_tb  = present;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DISK_PRESENT;
    cfg_data_i  <= present;
    @(posedge clk_i);
    cfg_index_i <= CFG_DISK_SIDE;
    cfg_data_i  <= side;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int start;
    int next_cfg;
    logic [7:0] ctrl;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load the start of both sides; the head is rewound before it leaves this window
    for (int s = 0; s < SIDES_DEFAULT; s++)
      for (int a = 0; a < WINDOW; a++)
        send_item(CMD_LOAD, 12'($urandom), 8'($urandom), 17'(s * SIDE_BYTES + a));

    // no disk inserted
    do_read(OFF_STATUS);
    do_read(OFF_RD_DATA);
    do_read(OFF_DRIVE);
    do_read(OFF_EXT);
    do_read(12'hFFF);
    do_read(12'h000);
    do_write(OFF_CONTROL, 8'hFF);
    do_write(12'hFFF, 8'h00);
    do_write(OFF_TIMER_LO, 8'h02);
    do_write(OFF_TIMER_HI, 8'h00);
    do_write(OFF_TIMER_MD, TIMER_LOOP);
    do_ticks(5);
    do_read(OFF_STATUS);

    set_drive(1'b1, 1'b0);
    do_write(OFF_IO_EN, IO_EN_WRITE);
    do_write(OFF_CONTROL, CTRL_IRQ_EN | CTRL_XFER);
    // drop transfer mode at head zero: reverse saturates
    do_write(OFF_CONTROL, CTRL_IRQ_EN);
    repeat (3) do_read(OFF_RD_DATA);
    do_write(OFF_WR_DATA, 8'h00);
    do_write(OFF_WR_DATA, 8'hFF);
    do_write(OFF_WR_DATA, 8'hA5);
    do_read(OFF_DRIVE);
    do_write(OFF_TIMER_HI, 8'hFF);
    do_write(OFF_TIMER_LO, 8'hFF);

    do_write(OFF_CONTROL, CTRL_REWIND | CTRL_NO_SKIP);
    repeat (8) do_read(OFF_RD_DATA);

    set_drive(1'b1, 1'b1);
    steady   <= 1'b1;
    start    = items_sent;
    next_cfg = start + $urandom_range(200, 120);
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start >= 250) steady <= 1'b0;
      if (items_sent - start >= 500) hold_req <= 1'b1;
      if (items_sent >= next_cfg) begin
        set_drive($urandom_range(3) != 0, 1'($urandom_range(1)));
        next_cfg = items_sent + $urandom_range(200, 120);
      end
      if (rd_since_rewind > WINDOW - REWIND_MARGIN) begin
        if (!disk_in_tb) set_drive(1'b1, 1'($urandom_range(1)));
        do_write(OFF_CONTROL, CTRL_REWIND);
      end
      case ($urandom_range(9))
        0, 1: begin
          do_write(OFF_TIMER_LO, 8'($urandom_range(20)));
          do_write(OFF_TIMER_HI, ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
          do_write(OFF_TIMER_MD, 8'($urandom));
          do_ticks($urandom_range(24, 1));
          do_read(OFF_STATUS);
        end
        2, 3: begin
          ctrl = 8'($urandom);
          if ($urandom_range(1)) ctrl |= CTRL_IRQ_EN;
          do_write(OFF_CONTROL, ctrl);
          repeat ($urandom_range(8, 1)) do_read(OFF_RD_DATA);
          do_ticks($urandom_range(90));
          do_read(OFF_STATUS);
        end
        4: begin
          do_write(OFF_IO_EN, 8'($urandom) | (($urandom_range(3) != 0) ? IO_EN_WRITE : 8'h00));
          ctrl = 8'($urandom);
          if ($urandom_range(3) != 0) ctrl &= ~CTRL_NO_SKIP;
          do_write(OFF_CONTROL, ctrl);
          repeat ($urandom_range(6, 1)) do_write(OFF_WR_DATA, 8'($urandom));
          do_read(OFF_RD_DATA);
        end
        5: do_ticks(($urandom_range(7) == 0) ? $urandom_range(270, 240) : $urandom_range(30, 1));
        6: do_read(OFF_STATUS + 12'($urandom_range(3)));
        7, 8: send_item(cmd_e'($urandom_range(3)),
                        ($urandom_range(3) == 0) ? 12'($urandom)
                                                 : OFF_TIMER_LO + 12'($urandom_range(19)),
                        8'($urandom), 17'($urandom));
        default: send_item(CMD_LOAD, 12'($urandom), 8'($urandom), 17'($urandom));
      endcase
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
